// ===== sv/dtq_pkg.sv =====
// Types and constants shared by the deadline timer queue and its slot cells.
package dtq_pkg;

  localparam int DL_W  = 49;
  localparam int NOW_W = 48;
  localparam int PER_W = 48;   // widest period a cell may hold
  localparam int IDX_W = 8;    // widest slot index (up to 256 slots)
  localparam logic [NOW_W-1:0] HOUR_MS = 48'd3600000;
  localparam logic [DL_W-1:0]  DL_MAX  = {DL_W{1'b1}};

  // input kinds
  localparam logic [2:0] K_ADD     = 3'd0;
  localparam logic [2:0] K_TICK    = 3'd1;
  localparam logic [2:0] K_RESET   = 3'd2;
  localparam logic [2:0] K_REFRESH = 3'd3;
  localparam logic [2:0] K_DISABLE = 3'd4;
  localparam logic [2:0] K_STATUS  = 3'd5;

  // result codes
  localparam logic [3:0] E_ADDED    = 4'd0;
  localparam logic [3:0] E_FULL     = 4'd1;
  localparam logic [3:0] E_FIRED    = 4'd2;
  localparam logic [3:0] E_NONE_DUE = 4'd3;
  localparam logic [3:0] E_CHANGED  = 4'd4;
  localparam logic [3:0] E_BAD_SLOT = 4'd5;
  localparam logic [3:0] E_REFRESH  = 4'd6;
  localparam logic [3:0] E_DISABLED = 4'd7;
  localparam logic [3:0] E_STATUS   = 4'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] now_ms;
    logic [31:0] period_ms;
    logic        repeat_flag;
    logic [3:0]  slot_sel;
    logic        shift_deadline;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic [3:0]  timer_slot;
    logic        at_front;
    logic        rearmed;
    logic [31:0] wait_ms;
    logic        any_timer;
    logic        time_jumped;
    logic        last_result;
  } out_item_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    C_NONE, C_NEW, C_REARM, C_FREE, C_SETPER, C_DISABLE, C_REFRESH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] sel;
    logic [DL_W-1:0]  dl;
    logic [PER_W-1:0] per;
    logic             rep;
    logic [NOW_W-1:0] now;
  } cmd_t;

  // running scan result handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [DL_W-1:0]  best_dl;
    logic [IDX_W-1:0] best_idx;
    logic [PER_W-1:0] best_per;
    logic             best_rc;
    logic             best_rn;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             sel_occ;
    logic [DL_W-1:0]  sel_dl;
    logic [PER_W-1:0] sel_per;
  } scan_t;

endpackage

// ===== sv/dtq_cell.sv =====
// One timer slot: holds its entry and folds itself into the passing scan.
module dtq_cell import dtq_pkg::*; #(
  parameter int IDX = 0,
  parameter int PB  = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  scan_t sin,
  output scan_t sout_r
);

  logic            occ_r, rc_r, rn_r;
  logic [DL_W-1:0] dl_r;
  logic [PB-1:0]   per_r;
  logic            hit;
  logic [DL_W-1:0] rearm_dl;
  scan_t           s_nxt;

  assign hit      = (cmd.idx == IDX_W'(IDX));
  assign rearm_dl = DL_W'(cmd.now) + DL_W'(per_r);

  // slot state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      case (cmd.op)
        C_NEW: if (hit) begin
          occ_r <= 1'b1;
          rn_r  <= 1'b1;
          rc_r  <= cmd.rep;
          dl_r  <= cmd.dl;
          per_r <= PB'(cmd.per);
        end
        C_REARM:   if (hit) dl_r <= rearm_dl;
        C_FREE:    if (hit) occ_r <= 1'b0;
        C_SETPER: if (hit) begin
          dl_r  <= cmd.dl;
          per_r <= PB'(cmd.per);
        end
        C_DISABLE: if (hit) rn_r <= 1'b0;
        C_REFRESH: if (occ_r) dl_r <= rearm_dl;
        default: ;
      endcase
    end
  end

  // fold this slot into the scan: earliest, first free, selected
  always_comb begin
    s_nxt = sin;
    if (occ_r && (!sin.found || dl_r < sin.best_dl)) begin
      s_nxt.found    = 1'b1;
      s_nxt.best_dl  = dl_r;
      s_nxt.best_idx = IDX_W'(IDX);
      s_nxt.best_per = PER_W'(per_r);
      s_nxt.best_rc  = rc_r;
      s_nxt.best_rn  = rn_r;
    end
    if (!occ_r && !sin.free_found) begin
      s_nxt.free_found = 1'b1;
      s_nxt.free_idx   = IDX_W'(IDX);
    end
    if (cmd.sel == IDX_W'(IDX)) begin
      s_nxt.sel_occ = occ_r;
      s_nxt.sel_dl  = dl_r;
      s_nxt.sel_per = PER_W'(per_r);
    end
  end

  always_ff @(posedge clk) begin
    sout_r <= s_nxt;
  end

endmodule

// ===== sv/deadline_timer_queue.sv =====
// Deadline timer queue: top level with controller and the row of slot cells.
//
// Input channel in_valid/in_ready/in_item takes one event (add, tick, reset
// period, refresh, disable, status). Results leave on out_valid/out_ready/
// out_item, one per event except tick, which gives one per fired entry, or
// one none-due result if nothing fired; a disabled due entry is freed
// silently. last_result marks the final one. Kinds 6 and 7 give no result.
// Every event waits for one scan down the cell row, which passes one cell
// per cycle. A tick rescans after each due entry, so it takes one scan per
// due entry plus a final one. One event is handled at a time; in_ready is
// high only between events. The output register lets the block take the
// next event while the last result is still waiting.
// If the receiver stalls, a tick holds its next fired entry until the output
// register frees. Reset clears all occupied marks and the last check time;
// nothing else needs clearing.
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int SLOTS       = 16,
  parameter int PERIOD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [0:0] {S_IDLE, S_SCAN} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  in_item_t         req_r;
  logic [NOW_W-1:0] lct_r;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             pend_v_r;
  out_item_t        pend_r;

  cmd_t             cmd;
  scan_t            link [0:SLOTS];
  scan_t            res;
  logic             done, can_push, due, sel_ok;
  logic [PERIOD_BITS-1:0] per_in;
  logic [DL_W-1:0]  now_x, add_dl, new_dl, wdiff;
  logic [PER_W-1:0] per_x, pdiff;
  logic [DL_W:0]    up_sum;
  logic [31:0]      wait_v;
  logic             jump_v;
  out_item_t        out_nxt;
  out_item_t        fire_item;
  logic             push_out;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign can_push  = !out_valid_r || out_ready;
  assign done      = (state_r == S_SCAN) && (cnt_r == CNT_W'(SLOTS));
  assign res       = link[SLOTS];

  // request arithmetic
  assign per_in = PERIOD_BITS'(req_r.period_ms);
  assign per_x  = PER_W'(per_in);
  assign now_x  = DL_W'(req_r.now_ms);
  assign add_dl = now_x + DL_W'(per_in);
  assign due    = res.found && (res.best_dl < now_x);
  assign sel_ok = (9'(req_r.slot_sel) < 9'(SLOTS)) && res.sel_occ;

  // deadline shift with saturation
  always_comb begin
    pdiff  = '0;
    up_sum = '0;
    new_dl = res.sel_dl;
    if (req_r.shift_deadline) begin
      if (per_x > res.sel_per) begin
        pdiff  = per_x - res.sel_per;
        up_sum = {1'b0, res.sel_dl} + (DL_W + 1)'(pdiff);
        new_dl = up_sum[DL_W] ? DL_MAX : up_sum[DL_W-1:0];
      end else begin
        pdiff  = res.sel_per - per_x;
        new_dl = (res.sel_dl < DL_W'(pdiff)) ? '0 : res.sel_dl - DL_W'(pdiff);
      end
    end
  end

  // status figures
  assign wdiff  = res.best_dl - now_x;
  assign wait_v = (!res.found || res.best_dl <= now_x) ? 32'd0 :
                  (wdiff > DL_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : wdiff[31:0];
  assign jump_v = (lct_r < req_r.now_ms) && ((req_r.now_ms - lct_r) > HOUR_MS);

  // command to the cells
  always_comb begin
    cmd     = '0;
    cmd.op  = C_NONE;
    cmd.sel = IDX_W'(req_r.slot_sel);
    cmd.now = req_r.now_ms;
    cmd.rep = req_r.repeat_flag;
    cmd.per = per_x;
    if (done) begin
      case (req_r.kind)
        K_ADD: if (can_push && res.free_found) begin
          cmd.op  = C_NEW;
          cmd.idx = res.free_idx;
          cmd.dl  = add_dl;
        end
        K_TICK: if (due) begin
          cmd.idx = res.best_idx;
          if (!res.best_rn) cmd.op = C_FREE;
          else if (!pend_v_r || can_push) cmd.op = res.best_rc ? C_REARM : C_FREE;
        end
        K_RESET: if (can_push && sel_ok) begin
          cmd.op  = C_SETPER;
          cmd.idx = IDX_W'(req_r.slot_sel);
          cmd.dl  = new_dl;
        end
        K_DISABLE: if (can_push && sel_ok) begin
          cmd.op  = C_DISABLE;
          cmd.idx = IDX_W'(req_r.slot_sel);
        end
        K_REFRESH: if (can_push) cmd.op = C_REFRESH;
        default: ;
      endcase
    end
  end

  // row of slot cells
  assign link[0] = '0;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dtq_cell #(.IDX(g), .PB(PERIOD_BITS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .sin    (link[g]),
      .sout_r (link[g+1])
    );
  end

  // fired entry as it goes into the pending register
  always_comb begin
    fire_item            = '0;
    fire_item.event_code = E_FIRED;
    fire_item.timer_slot = 4'(res.best_idx);
    fire_item.rearmed    = res.best_rc;
  end

  // item loaded into the output register this cycle
  always_comb begin
    push_out            = 1'b0;
    out_nxt             = '0;
    out_nxt.last_result = 1'b1;
    if (done && can_push) begin
      case (req_r.kind)
        K_TICK: begin
          if (due && res.best_rn) begin
            // earlier fired entry leaves, a later one replaces it
            push_out = pend_v_r;
            out_nxt  = pend_r;
          end else if (!due) begin
            push_out = 1'b1;
            if (pend_v_r) begin
              out_nxt             = pend_r;
              out_nxt.last_result = 1'b1;
            end else begin
              out_nxt.event_code = E_NONE_DUE;
            end
          end
        end
        K_ADD: begin
          push_out = 1'b1;
          if (res.free_found) begin
            out_nxt.event_code = E_ADDED;
            out_nxt.timer_slot = 4'(res.free_idx);
            out_nxt.at_front   = !res.found || (add_dl < res.best_dl);
          end else begin
            out_nxt.event_code = E_FULL;
          end
        end
        K_RESET, K_DISABLE: begin
          push_out           = 1'b1;
          out_nxt.timer_slot = req_r.slot_sel;
          out_nxt.event_code = !sel_ok ? E_BAD_SLOT :
                               (req_r.kind == K_RESET) ? E_CHANGED : E_DISABLED;
        end
        K_REFRESH: begin
          push_out           = 1'b1;
          out_nxt.event_code = E_REFRESH;
        end
        K_STATUS: begin
          push_out            = 1'b1;
          out_nxt.event_code  = E_STATUS;
          out_nxt.wait_ms     = wait_v;
          out_nxt.any_timer   = res.found;
          out_nxt.time_jumped = jump_v;
        end
        default: ;
      endcase
    end
  end

  // controller and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lct_r       <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (push_out) begin
        out_valid_r <= 1'b1;
        out_r       <= out_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          req_r   <= in_item;
          cnt_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (!done) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            case (req_r.kind)
              K_TICK: begin
                if (due && !res.best_rn) begin
                  cnt_r <= '0;
                end else if (due) begin
                  if (!pend_v_r || can_push) begin
                    pend_v_r <= 1'b1;
                    pend_r   <= fire_item;
                    cnt_r    <= '0;
                  end
                end else if (can_push) begin
                  pend_v_r <= 1'b0;
                  lct_r    <= req_r.now_ms;
                  state_r  <= S_IDLE;
                end
              end
              K_ADD, K_RESET, K_DISABLE, K_STATUS: if (can_push) begin
                state_r <= S_IDLE;
              end
              K_REFRESH: if (can_push) begin
                lct_r   <= req_r.now_ms;
                state_r <= S_IDLE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // no tick result may be held back once the block is idle again
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending fired entry left behind");

  // an accepted item always starts a fresh scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN && cnt_r == '0))
    else $error("accepted item did not start a scan");

  // a non-final result means its tick is still being worked on
  a_nonfinal_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_result) |-> (state_r != S_IDLE))
    else $error("non-final result while idle");

endmodule
